@@ sv/aes_pkg.sv @@
// Package for the AES-128 block cipher: request and response structs,
// the forward and inverse S-box tables and the round helper functions.
// Depends on nothing; used by aes128_block_cipher_top.
package aes_pkg;

    localparam int NumRounds = 10;

    typedef struct packed {
        logic        req_type;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_req;

    typedef struct packed {
        logic        done_op;
        logic [63:0] result_high;
        logic [63:0] result_low;
    } t_out_rsp;

    localparam logic OpEncrypt = 1'b0;
    localparam logic OpDecrypt = 1'b1;

    // Configuration register indexes.
    localparam logic [7:0] CfgKeyHigh = 8'd0;
    localparam logic [7:0] CfgKeyLow  = 8'd1;

    localparam logic [7:0] Sbox [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    localparam logic [7:0] InvSbox [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    // MixColumns coefficient rows, first entry multiplies the own byte.
    localparam logic [3:0][7:0] MixFwd = {8'd1, 8'd1, 8'd3, 8'd2};
    localparam logic [3:0][7:0] MixInv = {8'd9, 8'd13, 8'd11, 8'd14};

    // Doubling in GF(2^8) modulo x^8+x^4+x^3+x+1.
    function automatic logic [7:0] xt(input logic [7:0] a);
        xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        logic [7:0] x;
        r = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) begin
                r = r ^ x;
            end
            x = xt(x);
        end
        gmul = r;
    endfunction

    // SubBytes then ShiftRows; byte i sits at bits 127-8i downwards.
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 8 * (r + 4 * c) -: 8] = Sbox[s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8]];
            end
        end
        sub_shift = t;
    endfunction

    // Inverse ShiftRows then inverse SubBytes.
    function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = InvSbox[s[127 - 8 * (r + 4 * c) -: 8]];
            end
        end
        inv_shift_sub = t;
    endfunction

    // Column mixing with a circulant coefficient row.
    function automatic logic [127:0] mix(input logic [127:0] s, input logic [3:0][7:0] m);
        logic [127:0] t;
        logic [7:0]   o;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                o = '0;
                for (int j = 0; j < 4; j++) begin
                    o = o ^ gmul(m[(j - r) & 3], s[127 - 8 * (j + 4 * c) -: 8]);
                end
                t[127 - 8 * (r + 4 * c) -: 8] = o;
            end
        end
        mix = t;
    endfunction

    // One step of the key schedule: next round key from the previous one.
    function automatic logic [127:0] key_step(input logic [127:0] k, input logic [7:0] rcon);
        logic [31:0] t;
        logic [31:0] w4;
        logic [31:0] w5;
        logic [31:0] w6;
        logic [31:0] w7;
        t  = {Sbox[k[23:16]] ^ rcon, Sbox[k[15:8]], Sbox[k[7:0]], Sbox[k[31:24]]};
        w4 = k[127:96] ^ t;
        w5 = k[95:64] ^ w4;
        w6 = k[63:32] ^ w5;
        w7 = k[31:0] ^ w6;
        key_step = {w4, w5, w6, w7};
    endfunction

endpackage

@@ sv/aes128_block_cipher_top.sv @@
// AES-128 ECB cipher, encrypt or decrypt per request, fully unrolled pipeline.
// Depends on aes_pkg for the structs, S-box tables and round functions.
//
// Usage:
//   Request channel (i_in_valid / o_in_ready) carries one 128-bit block and
//   the operation bit. Response channel (o_out_valid / i_out_ready) returns
//   the result tagged with the operation. The key is written through the
//   configuration channel: index 0 is the upper key half, index 1 the lower.
//   Writes to other indexes are dropped.
// Pipeline and throughput:
//   Eleven register stages (initial key addition and ten rounds, the last
//   one being the output register). One request is taken in every cycle
//   unless the pipeline is stalled or the key schedule is being rebuilt.
// Key schedule:
//   After reset and after each key write, the round keys are rebuilt by an
//   iterative expander producing one round key per cycle, so o_in_ready is
//   low until all ten round keys are built. Reset gives the all-zero key.
// Stalls:
//   When the output holds a response and i_out_ready is low, the whole
//   pipeline freezes; nothing is lost or repeated.
module aes128_block_cipher_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  aes_pkg::t_in_req     i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output aes_pkg::t_out_rsp    o_out_rsp,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [7:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data
);
    import aes_pkg::*;

    logic [63:0]  r_key_high;
    logic [63:0]  r_key_low;
    logic         r_kbusy;
    logic [3:0]   r_kcnt;
    logic [7:0]   r_rcon;
    logic [127:0] r_kw;
    logic [127:0] r_rk [1:NumRounds];
    logic [127:0] w_rk [0:NumRounds];
    logic [127:0] w_kprev;
    logic [127:0] w_knext;
    logic [3:0]   w_kidx;
    logic         w_cfg_fire;
    logic         w_key_wr;

    logic         w_adv;
    logic         w_in_fire;
    logic         r_vld [0:NumRounds];
    logic         r_op  [0:NumRounds];
    logic [127:0] r_st  [0:NumRounds];
    logic [127:0] n_st  [0:NumRounds];
    logic [127:0] w_blk;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_fire  = i_cfg_valid;
    assign w_key_wr    = w_cfg_fire && (i_cfg_index == CfgKeyHigh || i_cfg_index == CfgKeyLow);

    // Round key 0 is the key itself.
    assign w_rk[0] = {r_key_high, r_key_low};
    for (genvar g = 1; g <= NumRounds; g++) begin : g_rk
        assign w_rk[g] = r_rk[g];
    end

    // Key expander: one round key per cycle from the previous one.
    assign w_kprev = (r_kcnt == 4'd0) ? w_rk[0] : r_kw;
    assign w_knext = key_step(w_kprev, r_rcon);
    assign w_kidx  = r_kcnt + 4'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_kbusy    <= 1'b1;
            r_kcnt     <= '0;
            r_rcon     <= 8'h01;
        end else if (w_key_wr) begin
            if (i_cfg_index == CfgKeyHigh) begin
                r_key_high <= i_cfg_data;
            end else begin
                r_key_low <= i_cfg_data;
            end
            r_kbusy <= 1'b1;
            r_kcnt  <= '0;
            r_rcon  <= 8'h01;
        end else if (r_kbusy) begin
            r_rcon <= xt(r_rcon);
            r_kcnt <= w_kidx;
            if (r_kcnt == 4'(NumRounds - 1)) begin
                r_kbusy <= 1'b0;
            end
        end
    end

    // Round key store, written one entry per expander step.
    always_ff @(posedge i_clk) begin
        if (r_kbusy && !w_key_wr) begin
            r_kw           <= w_knext;
            r_rk[w_kidx]   <= w_knext;
        end
    end

    // Pipeline advances whenever the output register is free or drained.
    assign w_adv      = !r_vld[NumRounds] || i_out_ready;
    assign o_in_ready = w_adv && !r_kbusy;
    assign w_in_fire  = i_in_valid && o_in_ready;

    // Stage 0: initial key addition, round key 0 or 10 by operation.
    assign w_blk   = {i_in_req.block_high, i_in_req.block_low};
    assign n_st[0] = w_blk ^ ((i_in_req.req_type == OpDecrypt) ? w_rk[NumRounds] : w_rk[0]);

    // Stages 1 to 10: one full round each, direction chosen per request.
    for (genvar j = 1; j <= NumRounds; j++) begin : g_round
        always_comb begin
            logic [127:0] x;
            if (r_op[j - 1] == OpDecrypt) begin
                x = inv_shift_sub(r_st[j - 1]) ^ w_rk[NumRounds - j];
                if (j < NumRounds) begin
                    x = mix(x, MixInv);
                end
            end else begin
                x = sub_shift(r_st[j - 1]);
                if (j < NumRounds) begin
                    x = mix(x, MixFwd);
                end
                x = x ^ w_rk[j];
            end
            n_st[j] = x;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NumRounds; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_adv) begin
            r_vld[0] <= w_in_fire;
            for (int k = 1; k <= NumRounds; k++) begin
                r_vld[k] <= r_vld[k - 1];
            end
        end
    end

    // Stage data and operation tags.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0] <= n_st[0];
            r_op[0] <= i_in_req.req_type;
            for (int k = 1; k <= NumRounds; k++) begin
                r_st[k] <= n_st[k];
                r_op[k] <= r_op[k - 1];
            end
        end
    end

    // Output register is the last stage.
    assign o_out_valid           = r_vld[NumRounds];
    assign o_out_rsp.done_op     = r_op[NumRounds];
    assign o_out_rsp.result_high = r_st[NumRounds][127:64];
    assign o_out_rsp.result_low  = r_st[NumRounds][63:0];

endmodule
